### rtl/core/spfe_pkg.sv
// Shared types and constants for the sign packet framer/escaper.
// No dependencies; every other file of the block refers to this package.
package spfe_pkg;

	localparam int BYTE_W  = 8;
	localparam int FMT_W   = 2;
	localparam int CFG_IDX_W = 2;

	// escape format codes (unused code behaves as plain)
	localparam logic [FMT_W-1:0] FMT_PLAIN = 2'd0;
	localparam logic [FMT_W-1:0] FMT_TWO   = 2'd1;
	localparam logic [FMT_W-1:0] FMT_THREE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGN_TYPE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGN_ADDRESS  = 2'd2;

	// register reset values
	localparam logic [FMT_W-1:0]  RST_ESCAPE_FORMAT = FMT_PLAIN;
	localparam logic [BYTE_W-1:0] RST_SIGN_TYPE     = 8'd90;
	localparam logic [BYTE_W-1:0] RST_SIGN_ADDRESS  = 8'd48;

	// link characters
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
	localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
	localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
	localparam logic [BYTE_W-1:0] CH_ESC_TWO   = 8'h5d; // ']'
	localparam logic [BYTE_W-1:0] CH_ESC_THREE = 8'h5f; // '_'
	localparam logic [BYTE_W-1:0] CTRL_LIMIT   = 8'h20;
	localparam logic [BYTE_W-1:0] TWO_OFFSET   = 8'h20;
	localparam logic [BYTE_W-1:0] NIB_OFFSET   = 8'h30;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_of_packet;
		logic              last_of_packet;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

### rtl/core/spfe_ifs.sv
// Channel interfaces of the sign packet framer/escaper: input, output, config.
// Widths taken from spfe_pkg.
interface spfe_in_if;
	logic                         valid;
	logic                         ready;
	logic [spfe_pkg::BYTE_W-1:0]  data_byte;
	logic                         first_of_packet;
	logic                         last_of_packet;
	modport source (output valid, output data_byte, output first_of_packet,
		output last_of_packet, input ready);
	modport sink (input valid, input data_byte, input first_of_packet,
		input last_of_packet, output ready);
endinterface

interface spfe_out_if;
	logic                         valid;
	logic                         ready;
	logic [spfe_pkg::BYTE_W-1:0]  out_byte;
	logic                         last_of_burst;
	modport source (output valid, output out_byte, output last_of_burst, input ready);
	modport sink (input valid, input out_byte, input last_of_burst, output ready);
endinterface

interface spfe_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [spfe_pkg::CFG_IDX_W-1:0]  index;
	logic [spfe_pkg::BYTE_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/spfe_queue.sv
// Front end: accepts input transactions into a two-entry show-ahead queue.
// Depends on spfe_pkg.
module spfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spfe_pkg::item_t     push_item,
	output logic                not_full,
	input  logic                pop,
	output spfe_pkg::head_t     head
);

	spfe_pkg::item_t  mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full = (count_q != 2'd2);
	assign do_push  = push && not_full;
	assign do_pop   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/spfe_back.sv
// Back end: walks the frame symbols of the queue head, escapes each one
// and drives the output byte register. Depends on spfe_pkg.
module spfe_back #(
	parameter int PREAMBLE_NULS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spfe_pkg::head_t                head,
	output logic                           pop,
	input  logic [spfe_pkg::FMT_W-1:0]     escape_format,
	input  logic [spfe_pkg::BYTE_W-1:0]    sign_type,
	input  logic [spfe_pkg::BYTE_W-1:0]    sign_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [spfe_pkg::BYTE_W-1:0]    out_byte,
	output logic                           last_of_burst
);

	localparam int CNT_W = (PREAMBLE_NULS > 1) ? $clog2(PREAMBLE_NULS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST =
		CNT_W'((PREAMBLE_NULS > 0) ? PREAMBLE_NULS - 1 : 0);

	// symbol phases; PH_START means "take the start phase from the head"
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_NUL   = 3'd1;
	localparam logic [2:0] PH_SOH   = 3'd2;
	localparam logic [2:0] PH_TYPE  = 3'd3;
	localparam logic [2:0] PH_ADDR  = 3'd4;
	localparam logic [2:0] PH_STX   = 3'd5;
	localparam logic [2:0] PH_DATA  = 3'd6;
	localparam logic [2:0] PH_EOT   = 3'd7;

	logic [2:0]                    phase_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [1:0]                    sub_q;
	logic                          out_valid_q;
	logic [spfe_pkg::BYTE_W-1:0]   out_byte_q;
	logic                          out_last_q;

	logic [2:0]                    phase;
	logic [spfe_pkg::BYTE_W-1:0]   sym;
	logic [1:0]                    sub_last;
	logic [spfe_pkg::BYTE_W-1:0]   esc_byte;
	logic                          load;
	logic                          sym_end;
	logic                          done;
	logic [2:0]                    phase_nx;

	always_comb begin
		if (phase_q != PH_START) begin
			phase = phase_q;
		end else if (head.item.first_of_packet) begin
			phase = (PREAMBLE_NULS > 0) ? PH_NUL : PH_SOH;
		end else begin
			phase = PH_DATA;
		end
	end

	always_comb begin
		unique case (phase)
			PH_SOH:  sym = spfe_pkg::CH_SOH;
			PH_TYPE: sym = sign_type;
			PH_ADDR: sym = sign_address;
			PH_STX:  sym = spfe_pkg::CH_STX;
			PH_DATA: sym = head.item.data_byte;
			PH_EOT:  sym = spfe_pkg::CH_EOT;
			default: sym = spfe_pkg::CH_NUL;
		endcase
	end

	// escape of one symbol: index of its last byte, and the byte at sub_q
	always_comb begin
		sub_last = 2'd0;
		esc_byte = sym;
		if (sym < spfe_pkg::CTRL_LIMIT) begin
			priority if (escape_format == spfe_pkg::FMT_TWO) begin
				sub_last = 2'd1;
				esc_byte = (sub_q == 2'd0) ? spfe_pkg::CH_ESC_TWO
					: sym + spfe_pkg::TWO_OFFSET;
			end else if (escape_format == spfe_pkg::FMT_THREE) begin
				sub_last = 2'd2;
				unique case (sub_q)
					2'd0:    esc_byte = spfe_pkg::CH_ESC_THREE;
					2'd1:    esc_byte = spfe_pkg::NIB_OFFSET + {4'h0, sym[7:4]};
					default: esc_byte = spfe_pkg::NIB_OFFSET + {4'h0, sym[3:0]};
				endcase
			end else begin
				sub_last = 2'd0;
			end
		end
	end

	assign load    = head.valid && (!out_valid_q || out_ready);
	assign sym_end = (sub_q == sub_last);

	always_comb begin
		done     = 1'b0;
		phase_nx = phase;
		unique case (phase)
			PH_NUL:  phase_nx = (cnt_q == CNT_LAST) ? PH_SOH : PH_NUL;
			PH_SOH:  phase_nx = PH_TYPE;
			PH_TYPE: phase_nx = PH_ADDR;
			PH_ADDR: phase_nx = PH_STX;
			PH_STX:  phase_nx = PH_DATA;
			PH_DATA: begin
				phase_nx = head.item.last_of_packet ? PH_EOT : PH_START;
				done     = !head.item.last_of_packet;
			end
			PH_EOT: begin
				phase_nx = PH_START;
				done     = 1'b1;
			end
			default: phase_nx = PH_START;
		endcase
	end

	assign pop = load && sym_end && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			cnt_q       <= '0;
			sub_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (!sym_end) begin
					sub_q   <= sub_q + 2'd1;
					phase_q <= phase;
				end else begin
					sub_q   <= 2'd0;
					phase_q <= phase_nx;
					if (phase == PH_NUL) begin
						cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= esc_byte;
			out_last_q <= sym_end && done;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_of_burst = out_last_q;

endmodule

### rtl/core/sign_packet_framer_escaper.sv
// Sign packet framer/escaper. Each input transaction carries one payload
// byte with first/last-of-packet flags; the block emits one or more output
// transactions, one byte each, for every input transaction. A first byte is
// preceded by PREAMBLE_NULS NULs, SOH, sign type, sign address and STX; a
// last byte is followed by EOT. Any emitted byte below 0x20 is escaped per
// escape_format (0 plain, 1 ']' + byte+0x20, 2 '_' + two nibble digits;
// code 3 = plain).
// last_of_burst marks the final output byte caused by an input transaction.
// Rate: the output register moves one byte per cycle while out_ready holds;
// an input yields between 1 and 3*(PREAMBLE_NULS+6) output bytes (1 to 3
// for an unflagged byte); a two-entry queue lets the next input be taken
// while the current one is still being expanded. Config writes are always
// ready and must only be made while the block is idle.
// Depends on spfe_pkg, spfe_ifs, spfe_queue and spfe_back.
module sign_packet_framer_escaper #(
	parameter int PREAMBLE_NULS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	spfe_in_if.sink           in_ch,
	spfe_out_if.source        out_ch,
	spfe_cfg_if.sink          cfg_ch
);

	// configuration registers
	logic [spfe_pkg::FMT_W-1:0]   escape_format_q;
	logic [spfe_pkg::BYTE_W-1:0]  sign_type_q;
	logic [spfe_pkg::BYTE_W-1:0]  sign_address_q;

	spfe_pkg::item_t  in_item;
	spfe_pkg::head_t  head;
	logic             q_not_full;
	logic             pop;
	logic             in_take;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_format_q <= spfe_pkg::RST_ESCAPE_FORMAT;
			sign_type_q     <= spfe_pkg::RST_SIGN_TYPE;
			sign_address_q  <= spfe_pkg::RST_SIGN_ADDRESS;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				spfe_pkg::CFG_ESCAPE_FORMAT:
					escape_format_q <= cfg_ch.data[spfe_pkg::FMT_W-1:0];
				spfe_pkg::CFG_SIGN_TYPE:    sign_type_q    <= cfg_ch.data;
				spfe_pkg::CFG_SIGN_ADDRESS: sign_address_q <= cfg_ch.data;
				default: ; // index beyond the register list: ignored
			endcase
		end
	end

	// front: take input transactions into the queue
	assign in_ch.ready = q_not_full;
	assign in_take     = in_ch.valid && q_not_full;

	assign in_item.data_byte       = in_ch.data_byte;
	assign in_item.first_of_packet = in_ch.first_of_packet;
	assign in_item.last_of_packet  = in_ch.last_of_packet;

	spfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_take),
		.push_item (in_item),
		.not_full  (q_not_full),
		.pop       (pop),
		.head      (head)
	);

	// back: frame sequencing, escaping and output register
	spfe_back #(
		.PREAMBLE_NULS (PREAMBLE_NULS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.escape_format (escape_format_q),
		.sign_type     (sign_type_q),
		.sign_address  (sign_address_q),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_byte      (out_ch.out_byte),
		.last_of_burst (out_ch.last_of_burst)
	);

	// an accepted input is held in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> head.valid)
		else $error("accepted input missing from queue");

	// with escaping on, no control byte reaches the link
	a_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (escape_format_q == spfe_pkg::FMT_TWO ||
			escape_format_q == spfe_pkg::FMT_THREE)
		|-> out_ch.out_byte >= spfe_pkg::CTRL_LIMIT)
		else $error("unescaped control byte emitted");

	// the queue only drains through the back end
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

endmodule

### sim/sign_packet_framer_escaper_tb.sv
// Self-checking testbench for sign_packet_framer_escaper: a directed table, then random packets.
// Output bytes are predicted per input transaction and compared in order.
// Depends on spfe_pkg, spfe_ifs and the RTL of the block.
module sign_packet_framer_escaper_tb;

	localparam int PREAMBLE_NULS = 10;
	localparam int RANDOM_ITEMS  = 100;
	localparam int N_DIRECTED    = 20;
	localparam int SETTLE_CYCLES = 20;
	// index 3 maps to no register; writes there must change nothing
	localparam logic [spfe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	// format code 3 has no meaning of its own and behaves as plain
	localparam logic [spfe_pkg::FMT_W-1:0] FMT_UNUSED = 2'd3;

	// one byte on the serial side, with its end-of-burst mark
	typedef struct packed {
		logic [spfe_pkg::BYTE_W-1:0] value;
		logic                        burst_end;
	} framed_byte_t;

	// directed row: settings to run under, the input, and (optionally) the
	// burst typed in by hand; n_typed of zero leaves it to the predictor
	typedef struct packed {
		logic [spfe_pkg::FMT_W-1:0]       fmt;
		logic [spfe_pkg::BYTE_W-1:0]      stype;
		logic [spfe_pkg::BYTE_W-1:0]      saddr;
		spfe_pkg::item_t                  it;
		logic [1:0]                       n_typed;
		logic [0:2][spfe_pkg::BYTE_W-1:0] typed;
	} row_t;

	localparam row_t DIRECTED [0:N_DIRECTED-1] = '{
		// reset settings, plain format
		'{spfe_pkg::FMT_PLAIN, spfe_pkg::RST_SIGN_TYPE, spfe_pkg::RST_SIGN_ADDRESS,
			'{8'h41, 1'b0, 1'b0}, 2'd1, '{8'h41, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_PLAIN, spfe_pkg::RST_SIGN_TYPE, spfe_pkg::RST_SIGN_ADDRESS,
			'{8'h00, 1'b0, 1'b0}, 2'd1, '{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_PLAIN, spfe_pkg::RST_SIGN_TYPE, spfe_pkg::RST_SIGN_ADDRESS,
			'{8'hff, 1'b1, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_PLAIN, spfe_pkg::RST_SIGN_TYPE, spfe_pkg::RST_SIGN_ADDRESS,
			'{8'h1f, 1'b0, 1'b1}, 2'd2, '{8'h1f, spfe_pkg::CH_EOT, 8'h00}},
		// two-byte escape, extreme type and address
		'{spfe_pkg::FMT_TWO, 8'h00, 8'hff, '{8'h00, 1'b0, 1'b0}, 2'd2,
			'{8'h5d, 8'h20, 8'h00}},
		'{spfe_pkg::FMT_TWO, 8'h00, 8'hff, '{8'h1f, 1'b0, 1'b0}, 2'd2,
			'{8'h5d, 8'h3f, 8'h00}},
		'{spfe_pkg::FMT_TWO, 8'h00, 8'hff, '{8'h20, 1'b0, 1'b0}, 2'd1,
			'{8'h20, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_TWO, 8'h00, 8'hff, '{8'h7e, 1'b1, 1'b0}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_TWO, 8'h00, 8'hff, '{8'h05, 1'b0, 1'b1}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		// three-byte escape, type and address either side of the control limit
		'{spfe_pkg::FMT_THREE, 8'h1f, 8'h20, '{8'h00, 1'b0, 1'b0}, 2'd3,
			'{8'h5f, 8'h30, 8'h30}},
		'{spfe_pkg::FMT_THREE, 8'h1f, 8'h20, '{8'h1f, 1'b0, 1'b0}, 2'd3,
			'{8'h5f, 8'h31, 8'h3f}},
		'{spfe_pkg::FMT_THREE, 8'h1f, 8'h20, '{8'h10, 1'b0, 1'b0}, 2'd3,
			'{8'h5f, 8'h31, 8'h30}},
		'{spfe_pkg::FMT_THREE, 8'h1f, 8'h20, '{8'h80, 1'b1, 1'b1}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_THREE, 8'h1f, 8'h20, '{8'hff, 1'b0, 1'b0}, 2'd1,
			'{8'hff, 8'h00, 8'h00}},
		// unused code 3: must behave as plain
		'{FMT_UNUSED, 8'hff, 8'h00, '{8'h03, 1'b0, 1'b0}, 2'd1, '{8'h03, 8'h00, 8'h00}},
		'{FMT_UNUSED, 8'hff, 8'h00, '{8'h20, 1'b1, 1'b1}, 2'd0, '{8'h00, 8'h00, 8'h00}},
		// control characters, then printable ones, as type and address
		'{spfe_pkg::FMT_TWO, 8'h01, 8'h02, '{8'h01, 1'b1, 1'b0}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_TWO, 8'h01, 8'h02, '{8'haa, 1'b0, 1'b1}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_THREE, 8'ha5, 8'h5a, '{8'h0f, 1'b1, 1'b1}, 2'd0,
			'{8'h00, 8'h00, 8'h00}},
		'{spfe_pkg::FMT_THREE, 8'ha5, 8'h5a, '{8'h55, 1'b0, 1'b0}, 2'd1,
			'{8'h55, 8'h00, 8'h00}}
	};

	logic clk = 1'b0;
	logic arst_n;

	spfe_in_if  in_ch ();
	spfe_out_if out_ch ();
	spfe_cfg_if cfg_ch ();

	sign_packet_framer_escaper #(
		.PREAMBLE_NULS(PREAMBLE_NULS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// period of 2 time units
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the registers, kept in step with every config write
	logic [spfe_pkg::FMT_W-1:0]  cur_format    = spfe_pkg::RST_ESCAPE_FORMAT;
	logic [spfe_pkg::BYTE_W-1:0] cur_sign_type = spfe_pkg::RST_SIGN_TYPE;
	logic [spfe_pkg::BYTE_W-1:0] cur_sign_addr = spfe_pkg::RST_SIGN_ADDRESS;

	logic [spfe_pkg::BYTE_W-1:0] burst_bytes [$]; // burst being built for one transaction
	framed_byte_t      framed_due [$];  // serial bytes owed by the block, oldest first
	int                fail_count = 0;
	bit                quiet = 1'b0;    // set: no gaps on either side

	// Mostly no gap, some short, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Biased towards control bytes, as they are the ones that get escaped.
	function automatic logic [spfe_pkg::BYTE_W-1:0] rand_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range(0, 8'h1f));
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'h1f;
				2: return 8'h20;
				default: return 8'hff;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Escape one byte under the current format; bytes at or above 0x20 always pass.
	function automatic void push_escaped(input logic [spfe_pkg::BYTE_W-1:0] b);
		if (b >= spfe_pkg::CTRL_LIMIT) begin
			burst_bytes.push_back(b);
		end else begin
			case (cur_format)
				spfe_pkg::FMT_TWO: begin
					burst_bytes.push_back(spfe_pkg::CH_ESC_TWO);
					burst_bytes.push_back(b + spfe_pkg::TWO_OFFSET);
				end
				spfe_pkg::FMT_THREE: begin
					burst_bytes.push_back(spfe_pkg::CH_ESC_THREE);
					burst_bytes.push_back({4'h0, b[7:4]} + spfe_pkg::NIB_OFFSET);
					burst_bytes.push_back({4'h0, b[3:0]} + spfe_pkg::NIB_OFFSET);
				end
				default: begin // plain, and the unused code
					burst_bytes.push_back(b);
				end
			endcase
		end
	endfunction

	// Move the finished burst onto the owed queue, marking its final byte.
	function automatic void queue_burst();
		foreach (burst_bytes[k])
			framed_due.push_back(framed_byte_t'{burst_bytes[k],
				k == burst_bytes.size() - 1});
		burst_bytes.delete();
	endfunction

	// Full framing of one transaction: preamble, payload byte, EOT.
	function automatic void frame_item(input spfe_pkg::item_t it);
		burst_bytes.delete();
		if (it.first_of_packet) begin
			repeat (PREAMBLE_NULS)
				push_escaped(spfe_pkg::CH_NUL);
			push_escaped(spfe_pkg::CH_SOH);
			push_escaped(cur_sign_type);
			push_escaped(cur_sign_addr);
			push_escaped(spfe_pkg::CH_STX);
		end
		push_escaped(it.data_byte);
		if (it.last_of_packet)
			push_escaped(spfe_pkg::CH_EOT);
		queue_burst();
	endfunction

	// Offer one input transaction after a random gap. Called in an edge step;
	// returns in the step of acceptance with valid still high.
	task automatic send_item(input spfe_pkg::item_t it, input logic [1:0] n_typed,
			input logic [0:2][spfe_pkg::BYTE_W-1:0] typed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.data_byte       <= it.data_byte;
		in_ch.first_of_packet <= it.first_of_packet;
		in_ch.last_of_packet  <= it.last_of_packet;
		do @(posedge clk); while (!in_ch.ready);
		if (n_typed != 2'd0) begin
			burst_bytes.delete();
			for (int k = 0; k < n_typed; k++)
				burst_bytes.push_back(typed[k]);
			queue_burst();
		end else begin
			frame_item(it);
		end
	endtask

	// Drop the input and wait until every owed byte has come out.
	// Never returns without waiting on the clock, so the next valid rise is a separate step.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (framed_due.size() != 0);
	endtask

	// One config transaction; valid is left high for a following write.
	task automatic put_reg(input logic [spfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [spfe_pkg::BYTE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			spfe_pkg::CFG_ESCAPE_FORMAT: cur_format    = val[spfe_pkg::FMT_W-1:0];
			spfe_pkg::CFG_SIGN_TYPE:     cur_sign_type = val;
			spfe_pkg::CFG_SIGN_ADDRESS:  cur_sign_addr = val;
			default: ;
		endcase
	endtask

	// Write all three registers, now and then poking the unused index as well.
	task automatic load_settings(input logic [spfe_pkg::BYTE_W-1:0] fmt_byte,
			input logic [spfe_pkg::BYTE_W-1:0] stype,
			input logic [spfe_pkg::BYTE_W-1:0] saddr);
		put_reg(spfe_pkg::CFG_ESCAPE_FORMAT, fmt_byte);
		put_reg(spfe_pkg::CFG_SIGN_TYPE, stype);
		put_reg(spfe_pkg::CFG_SIGN_ADDRESS, saddr);
		if ($urandom_range(0, 3) == 0)
			put_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output side: compare every accepted byte with the oldest owed one.
	always @(posedge clk) begin : check_out
		framed_byte_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (framed_due.size() == 0) begin
				$error("unexpected output byte %02h (last_of_burst %0b)",
					out_ch.out_byte, out_ch.last_of_burst);
				fail_count++;
			end else begin
				want = framed_due.pop_front();
				if (out_ch.out_byte !== want.value) begin
					$error("out_byte: expected %02h, got %02h", want.value, out_ch.out_byte);
					fail_count++;
				end
				if (out_ch.last_of_burst !== want.burst_end) begin
					$error("last_of_burst: expected %0b, got %0b",
						want.burst_end, out_ch.last_of_burst);
					fail_count++;
				end
			end
		end
	end

	// Output back-pressure: runs of ready broken by stalls drawn like the input gaps.
	initial begin : out_pacing
		int span;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			span = $urandom_range(1, 20);
			repeat (span) @(posedge clk);
			span = pick_gap();
			if (span > 0) begin
				out_ch.ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin : watchdog
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int                          items_sent;
		int                          phase_left;
		int                          pkt_len;
		spfe_pkg::item_t             it;
		logic [spfe_pkg::BYTE_W-1:0] fmt_byte;

		in_ch.valid           = 1'b0;
		in_ch.data_byte       = '0;
		in_ch.first_of_packet = 1'b0;
		in_ch.last_of_packet  = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = spfe_pkg::CFG_ESCAPE_FORMAT;
		cfg_ch.data           = '0;
		arst_n                = 1'b0;

		// reset held low, then released on a falling edge, away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: settings change only once the block has gone idle.
		for (int r = 0; r < N_DIRECTED; r++) begin
			if (DIRECTED[r].fmt != cur_format || DIRECTED[r].stype != cur_sign_type ||
					DIRECTED[r].saddr != cur_sign_addr) begin
				wait_idle();
				load_settings({6'b0, DIRECTED[r].fmt}, DIRECTED[r].stype, DIRECTED[r].saddr);
			end
			send_item(DIRECTED[r].it, DIRECTED[r].n_typed, DIRECTED[r].typed);
		end

		// Random phases: fresh settings each time (spare format bits set at
		// random, they must be ignored), then mostly well-formed packets.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			fmt_byte = {6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))};
			load_settings(fmt_byte, rand_byte(), rand_byte());
			quiet      = ($urandom_range(0, 3) == 0);
			phase_left = $urandom_range(10, 30);
			while (phase_left > 0) begin
				pkt_len = $urandom_range(1, 6);
				for (int k = 0; k < pkt_len; k++) begin
					it.data_byte = rand_byte();
					if ($urandom_range(0, 99) < 20) begin
						// noise: flags anywhere, including broken packets
						it.first_of_packet = 1'($urandom_range(0, 1));
						it.last_of_packet  = 1'($urandom_range(0, 1));
					end else begin
						it.first_of_packet = (k == 0);
						it.last_of_packet  = (k == pkt_len - 1);
					end
					send_item(it, 2'd0, '0);
					items_sent++;
					phase_left--;
				end
			end
		end

		// Drain, then give any stray bytes time to show up.
		wait_idle();
		quiet = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
